// File: rtl/spq_pkg.sv
// spq_pkg: shared codes and control types for the sorted priority queue.
// Depends on nothing; spq_ctrl, spq_datapath, sorted_priority_queue and the bench import it.
package spq_pkg;

    // Operation codes carried in the func field
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the request operands
        logic execute;   // run the insert or remove on the cell row
    } spq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_blocked;   // a result is held and not taken this cycle
    } spq_sts_t;

endpackage

// File: rtl/spq_ifs.sv
// spq_ifs: valid/ready channel interfaces for requests and responses.
// Depends on nothing.
interface spq_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;

    modport source (output valid, output func, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input func, input item_value, input item_priority,
                    output ready);
endinterface

interface spq_out_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [31:0] out_value;

    modport source (output valid, output status, output out_value, input ready);
    modport sink   (input valid, input status, input out_value, output ready);
endinterface

// File: rtl/spq_ctrl.sv
// spq_ctrl: two-state sequencer for the sorted priority queue.
// Depends on spq_pkg for the command and status structs.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  spq_sts_t sts,
    output spq_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        req_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // wait until the result register can take a new result
                if (!sts.out_blocked)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/spq_datapath.sv
// spq_datapath: row of sorted cells, entry count, operand and result registers.
// Depends on spq_pkg. Cell 0 holds the tail (lowest priority, oldest among equals).
module spq_datapath
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  spq_cmd_t           cmd,
    output spq_sts_t           sts,
    input  logic               in_func,
    input  logic signed [31:0] in_value,
    input  logic signed [15:0] in_priority,
    output logic               out_valid,
    input  logic               out_ready,
    output logic        [1:0]  out_status,
    output logic signed [31:0] out_value
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Operand registers
    logic               op_func_reg;
    logic signed [31:0] op_val_reg;
    logic signed [15:0] op_pri_reg;

    // Cell row and fill count
    logic signed [31:0] val_reg  [QUEUE_DEPTH];
    logic signed [15:0] pri_reg  [QUEUE_DEPTH];
    logic signed [31:0] val_next [QUEUE_DEPTH];
    logic signed [15:0] pri_next [QUEUE_DEPTH];
    logic [CW-1:0]      count_reg, count_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic        [1:0]  out_status_reg, out_status_next;
    logic signed [31:0] out_value_reg, out_value_next;

    logic [QUEUE_DEPTH-1:0] shift_flag;   // cell moves up on insert
    logic [QUEUE_DEPTH-1:0] shift_below;  // cell below moves up into this one
    logic is_full, is_empty, do_insert, do_remove;

    assign is_full   = (count_reg == CW'(QUEUE_DEPTH));
    assign is_empty  = (count_reg == '0);
    assign do_insert = cmd.execute && (op_func_reg == FUNC_INSERT) && !is_full;
    assign do_remove = cmd.execute && (op_func_reg == FUNC_REMOVE) && !is_empty;

    assign sts.out_blocked = out_valid_reg && !out_ready;

    // Operand capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_func_reg <= in_func;
            op_val_reg  <= in_value;
            op_pri_reg  <= in_priority;
        end
    end

    // Cells: parallel compare against the new key, then shift or load
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        logic signed [31:0] above_val;
        logic signed [15:0] above_pri;
        logic signed [31:0] below_val;
        logic signed [15:0] below_pri;

        assign shift_flag[g] = (CW'(g) < count_reg) && (pri_reg[g] > op_pri_reg);

        if (g == 0)
        begin : g_bottom
            assign shift_below[g] = 1'b0;
            assign below_val      = val_reg[g];
            assign below_pri      = pri_reg[g];
        end
        else
        begin : g_mid_lo
            assign shift_below[g] = shift_flag[g-1];
            assign below_val      = val_reg[g-1];
            assign below_pri      = pri_reg[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_top
            assign above_val = val_reg[g];
            assign above_pri = pri_reg[g];
        end
        else
        begin : g_mid_hi
            assign above_val = val_reg[g+1];
            assign above_pri = pri_reg[g+1];
        end

        always_comb
        begin
            val_next[g] = val_reg[g];
            pri_next[g] = pri_reg[g];
            if (do_insert)
            begin
                if (shift_below[g])
                begin
                    val_next[g] = below_val;
                    pri_next[g] = below_pri;
                end
                else if (shift_flag[g] || (count_reg == CW'(g)))
                begin
                    val_next[g] = op_val_reg;
                    pri_next[g] = op_pri_reg;
                end
            end
            else if (do_remove)
            begin
                val_next[g] = above_val;
                pri_next[g] = above_pri;
            end
        end

        always_ff @(posedge clk)
        begin
            val_reg[g] <= val_next[g];
            pri_reg[g] <= pri_next[g];
        end
    end

    // Count and result
    always_comb
    begin
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        if (do_insert)
            count_next = count_reg + CW'(1);
        else if (do_remove)
            count_next = count_reg - CW'(1);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.execute)
        begin
            out_valid_next  = 1'b1;
            out_status_next = STATUS_OK;
            out_value_next  = '0;
            if (op_func_reg == FUNC_INSERT)
            begin
                if (is_full)
                    out_status_next = STATUS_FULL;
            end
            else if (is_empty)
                out_status_next = STATUS_EMPTY;
            else
                out_value_next = val_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;

endmodule

// File: rtl/sorted_priority_queue.sv
// Channel  Dir  Payload                              Transfer
// req      in   func, item_value, item_priority      req.valid && req.ready
// rsp      out  status, out_value                    rsp.valid && rsp.ready
//
// A request has its operands latched in ST_IDLE; then, in ST_EXEC, every
// cell compares its priority with the new key and shifts or loads in parallel.
// A request waits in the update cycle while the previous response is untaken.
// Reset clears the entry count and the response valid; cells are not cleared.
// Depends on spq_pkg, spq_ifs, spq_ctrl and spq_datapath.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    spq_in_if.sink    req,
    spq_out_if.source rsp
);

    spq_cmd_t cmd;
    spq_sts_t sts;

    // Sequencer
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Cell row and result register
    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_func     (req.func),
        .in_value    (req.item_value),
        .in_priority (req.item_priority),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_status  (rsp.status),
        .out_value   (rsp.out_value)
    );

endmodule

// File: tb/tb_sorted_priority_queue.sv
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue.
// Uses spq_pkg, spq_ifs and sorted_priority_queue. A directed table comes
// first, then random insert/remove traffic checked against a behavioral queue.
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1950;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE       = 20;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] value;
    } result_t;

    typedef struct {
        logic               func;
        logic signed [31:0] value;
        logic signed [15:0] prio;
        bit                 typed;
        logic [1:0]         want_status;
        logic signed [31:0] want_value;
    } table_row_t;

    logic clk;
    logic rst_n;

    spq_in_if  req ();
    spq_out_if rsp ();

    sorted_priority_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Behavioral copy of the queue, head (highest priority) at index 0
    logic signed [31:0] entry_vals  [DEPTH];
    logic signed [15:0] entry_prios [DEPTH];
    int                 entry_count;

    result_t    pending_results [$];
    table_row_t stim_table [$];
    int         fail_count;
    int         idle_cycles;
    bit         steady_flow;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Work out the response to one request and update the shadow queue
    function automatic result_t predict_queue_op(input logic f,
                                                 input logic signed [31:0] v,
                                                 input logic signed [15:0] p);
        result_t r;
        int      pos;
        r.status = STATUS_OK;
        r.value  = '0;
        if (f == FUNC_INSERT)
        begin
            if (entry_count >= DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                // new entry goes ahead of every equal or lower priority
                pos = 0;
                while (pos < entry_count && p < entry_prios[pos])
                begin
                    pos++;
                end
                for (int k = entry_count; k > pos; k--)
                begin
                    entry_vals[k]  = entry_vals[k-1];
                    entry_prios[k] = entry_prios[k-1];
                end
                entry_vals[pos]  = v;
                entry_prios[pos] = p;
                entry_count++;
            end
        end
        else if (entry_count == 0)
        begin
            r.status = STATUS_EMPTY;
        end
        else
        begin
            entry_count--;
            r.value = entry_vals[entry_count];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [15:0] pick_prio();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 16'($signed($urandom_range(0, 4)) - 2);
        else if (r == 4)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'sh7fff;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        else
            return 16'($urandom);
    endfunction

    task automatic add_row(input logic f, input logic signed [31:0] v,
                           input logic signed [15:0] p, input bit typed,
                           input logic [1:0] st, input logic signed [31:0] ov);
        table_row_t row;
        row.func        = f;
        row.value       = v;
        row.prio        = p;
        row.typed       = typed;
        row.want_status = st;
        row.want_value  = ov;
        stim_table.push_back(row);
    endtask

    // Present one request, wait for its transfer, record the expected response.
    // Entered and left on a rising edge; valid stays high across back-to-back items.
    task automatic send_request(input int gap, input table_row_t row);
        result_t predicted;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.func          <= row.func;
        req.item_value    <= row.value;
        req.item_priority <= row.prio;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        predicted = predict_queue_op(row.func, row.value, row.prio);
        if (row.typed)
        begin
            predicted.status = row.want_status;
            predicted.value  = row.want_value;
        end
        pending_results.push_back(predicted);
    endtask

    task automatic hold_until_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Response checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response with nothing expected: status %0d out_value %0d",
                       rsp.status, rsp.out_value);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.out_value !== want.value)
                begin
                    $error("out_value mismatch: expected %0d, actual %0d",
                           want.value, rsp.out_value);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Response side: random ready, with short and long stalls
    initial
    begin
        int stall;
        int r;
        stall     = 0;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (steady_flow || r < 65)
                begin
                    rsp.ready <= 1'b1;
                end
                else
                begin
                    stall     = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 30);
                    rsp.ready <= 1'b0;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        table_row_t row;
        int         issued;
        int         seg_len;
        int         mode;
        int         ins_weight;

        rst_n             = 1'b0;
        req.valid         = 1'b0;
        req.func          = FUNC_INSERT;
        req.item_value    = '0;
        req.item_priority = '0;
        entry_count       = 0;
        fail_count        = 0;
        idle_cycles       = 0;
        steady_flow       = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty, extremes, equal-priority order, full
        add_row(FUNC_REMOVE, 32'sh0, 16'sh0, 1'b1, STATUS_EMPTY, 32'sh0);
        add_row(FUNC_INSERT, 32'sh7fffffff, 16'sh7fff, 1'b1, STATUS_OK, 32'sh0);
        add_row(FUNC_INSERT, 32'sh80000000, 16'sh8000, 1'b1, STATUS_OK, 32'sh0);
        add_row(FUNC_REMOVE, 32'shffffffff, 16'shffff, 1'b1, STATUS_OK, 32'sh80000000);
        add_row(FUNC_REMOVE, 32'sh0, 16'sh0, 1'b1, STATUS_OK, 32'sh7fffffff);
        add_row(FUNC_REMOVE, 32'sh0, 16'sh0, 1'b1, STATUS_EMPTY, 32'sh0);
        // equal priorities leave oldest first
        add_row(FUNC_INSERT, 32'sd10, 16'sh0, 1'b0, STATUS_OK, 32'sh0);
        add_row(FUNC_INSERT, 32'sd11, 16'sh0, 1'b0, STATUS_OK, 32'sh0);
        add_row(FUNC_REMOVE, 32'sh0, 16'sh0, 1'b0, STATUS_OK, 32'sh0);
        add_row(FUNC_REMOVE, 32'sh0, 16'sh0, 1'b0, STATUS_OK, 32'sh0);
        // fill to capacity, then one insert too many
        for (int i = 0; i < DEPTH; i++)
        begin
            add_row(FUNC_INSERT, 32'(i * 7 - 50), 16'((i % 5) * 1000 - 2000),
                    1'b0, STATUS_OK, 32'sh0);
        end
        add_row(FUNC_INSERT, 32'sd99, 16'sh1234, 1'b1, STATUS_FULL, 32'sh0);

        foreach (stim_table[i])
        begin
            send_request(pick_gap(), stim_table[i]);
        end

        // Random traffic in segments biased toward fill, drain or balance
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            if (issued == 0 || $urandom_range(0, 7) == 0)
            begin
                steady_flow = 1'b0;
                hold_until_drained();
            end
            seg_len     = $urandom_range(4, 48);
            mode        = $urandom_range(0, 2);
            ins_weight  = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            steady_flow = ($urandom_range(0, 5) == 0);
            for (int j = 0; j < seg_len && issued < RANDOM_ITEMS; j++)
            begin
                row.func  = ($urandom_range(0, 99) < ins_weight) ? FUNC_INSERT : FUNC_REMOVE;
                row.value = ($urandom_range(0, 15) == 0) ?
                            (($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000) :
                            32'($urandom);
                row.prio  = pick_prio();
                row.typed = 1'b0;
                row.want_status = STATUS_OK;
                row.want_value  = '0;
                send_request(pick_gap(), row);
                issued++;
            end
        end

        steady_flow = 1'b0;
        hold_until_drained();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
